[rtl/pn_pkg.sv]
// Shared constants, types and state codes of the peak normalizer.
package pn_pkg;

	localparam int SAMPLE_BITS = 24;
	localparam int FRAC_BITS   = SAMPLE_BITS - 1;
	// 255/256 gain: multiply by 255 as (x << 8) - x, divide by 256 as a shift of the peak.
	localparam int GAIN_SHIFT  = 8;
	localparam int PROD_BITS   = SAMPLE_BITS + GAIN_SHIFT;
	localparam int STEP_BITS   = $clog2(SAMPLE_BITS + 1);
	// Queue depth must be a power of two: pointers wrap by overflow.
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
	localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

	localparam logic [SAMPLE_BITS-1:0] FULL_MAG = {1'b1, {FRAC_BITS{1'b0}}};
	localparam logic [SAMPLE_BITS-1:0] MAX_POS  = {1'b0, {FRAC_BITS{1'b1}}};

	typedef enum logic {
		OP_MEASURE = 1'b0,
		OP_SCALE   = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_FIN
	} state_t;

	typedef struct packed {
		op_t                    op;
		logic                   neg;
		logic [SAMPLE_BITS-1:0] mag;
		logic [SAMPLE_BITS-1:0] bits;
	} item_t;

endpackage

[rtl/pn_if.sv]
// Handshake channels of the peak normalizer: sample input and result output.
interface pn_in_if;
	import pn_pkg::*;

	logic                   valid;
	logic                   ready;
	logic                   opcode;
	logic [SAMPLE_BITS-1:0] sample_in;

	modport source (output valid, output opcode, output sample_in, input ready);
	modport sink (input valid, input opcode, input sample_in, output ready);
endinterface

interface pn_out_if;
	import pn_pkg::*;

	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] sample_out;
	logic [SAMPLE_BITS-1:0] peak_level;

	modport source (output valid, output sample_out, output peak_level, input ready);
	modport sink (input valid, input sample_out, input peak_level, output ready);
endinterface

[rtl/peak_normalizer.sv]
// Top level of the two-pass audio peak normalizer.
//
// Channels: samples (sink) carries opcode and sample_in, signed Q1.23;
// results (source) carries sample_out and peak_level. A beat moves when
// valid and ready are both high at a rising edge of clk.
// Opcode measure folds |sample_in| into the running peak and echoes the
// sample; opcode scale returns sample * 255/256 / peak, truncated toward
// zero and saturated, or the sample unchanged while the peak is zero.
// Every result beat also reports the peak after its item.
// A measure item, a scale item with zero peak, or a scale item that saturates
// outright passes through the queue register and the output register. A
// divided scale item is popped in ST_IDLE, takes 24 divider steps in ST_DIV,
// and is saturated and loaded into the output register in ST_FIN.
// Throughput: one measure item per cycle while results.ready stays high; the
// restoring divider retires one quotient bit per cycle, and no new item is
// popped until it is done. A 2-beat queue keeps the front taking beats meanwhile.
// Reset (arst_n low) clears the peak, the queue and the output valid flag.
// When the receiver stalls, the result holds in the output register, the
// back end pops no new item, and samples.ready drops once the queue fills.
module peak_normalizer (
	input  logic      clk,
	input  logic      arst_n,
	pn_in_if.sink     samples,
	pn_out_if.source  results
);
	import pn_pkg::*;

	item_t item;
	logic  item_valid;
	logic  pop;

	// Classify and queue incoming beats.
	pn_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.samples    (samples),
		.item       (item),
		.item_valid (item_valid),
		.pop        (pop)
	);

	// Track the peak, divide and drive the result channel.
	pn_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item),
		.item_valid (item_valid),
		.pop        (pop),
		.results    (results)
	);

endmodule

[rtl/pn_front.sv]
// Front end: accept input beats, classify them and hold them in a short queue.
module pn_front (
	input  logic          clk,
	input  logic          arst_n,
	pn_in_if.sink         samples,
	output pn_pkg::item_t item,
	output logic          item_valid,
	input  logic          pop
);
	import pn_pkg::*;

	item_t                  mem_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0]   wr_ptr_q;
	logic [QPTR_BITS-1:0]   rd_ptr_q;
	logic [QCNT_BITS-1:0]   count_q;
	item_t                  cls;
	logic                   push;
	logic                   pull;

	// Split the sample into sign and magnitude; the most negative code keeps 2^(N-1).
	always_comb begin
		cls.op   = op_t'(samples.opcode);
		cls.bits = samples.sample_in;
		cls.neg  = samples.sample_in[SAMPLE_BITS-1];
		cls.mag  = cls.neg ? (SAMPLE_BITS'(0) - samples.sample_in) : samples.sample_in;
	end

	assign samples.ready = (count_q != QCNT_BITS'(QUEUE_DEPTH));
	assign push          = samples.valid && samples.ready;
	assign item_valid    = (count_q != '0);
	assign pull          = pop && item_valid;
	assign item          = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_BITS'(1);
			end
			if (pull) begin
				rd_ptr_q <= rd_ptr_q + QPTR_BITS'(1);
			end
			unique case ({push, pull})
				2'b10:   count_q <= count_q + QCNT_BITS'(1);
				2'b01:   count_q <= count_q - QCNT_BITS'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[rtl/pn_back.sv]
// Back end: peak tracking, bit-serial divider, saturation and output register.
module pn_back (
	input  logic          clk,
	input  logic          arst_n,
	input  pn_pkg::item_t item,
	input  logic          item_valid,
	output logic          pop,
	pn_out_if.source      results
);
	import pn_pkg::*;

	state_t                 state_q;
	state_t                 state_d;
	logic [SAMPLE_BITS-1:0] peak_q;
	logic [PROD_BITS-1:0]   rem_q;
	logic [SAMPLE_BITS-1:0] num_q;
	logic [SAMPLE_BITS-1:0] quo_q;
	logic [STEP_BITS-1:0]   cnt_q;
	logic                   neg_q;
	logic                   out_vld_q;
	logic [SAMPLE_BITS-1:0] out_sample_q;
	logic [SAMPLE_BITS-1:0] out_peak_q;

	logic [PROD_BITS-1:0]   den;
	logic [PROD_BITS-1:0]   prod;
	logic [PROD_BITS-1:0]   top;
	logic                   ovf;
	logic [PROD_BITS:0]     shifted;
	logic                   ge;
	logic [PROD_BITS-1:0]   rem_nxt;
	logic [SAMPLE_BITS-1:0] peak_max;
	logic                   out_free;
	logic                   out_load;
	logic [SAMPLE_BITS-1:0] out_sample_d;
	logic [SAMPLE_BITS-1:0] out_peak_d;
	logic                   peak_load;
	logic                   div_start;
	logic                   div_step;

	function automatic logic [SAMPLE_BITS-1:0] sat_result(
		input logic                   neg,
		input logic                   over,
		input logic [SAMPLE_BITS-1:0] q
	);
		logic [SAMPLE_BITS-1:0] lim;
		logic [SAMPLE_BITS-1:0] mq;
		lim = neg ? FULL_MAG : MAX_POS;
		mq  = (over || (q > lim)) ? lim : q;
		return neg ? (SAMPLE_BITS'(0) - mq) : mq;
	endfunction

	// q = floor(mag*255 * 2^F / (peak*256)); the upper part of the dividend seeds the remainder.
	assign den      = {peak_q, {GAIN_SHIFT{1'b0}}};
	assign prod     = {item.mag, {GAIN_SHIFT{1'b0}}} - {{GAIN_SHIFT{1'b0}}, item.mag};
	assign top      = {1'b0, prod[PROD_BITS-1:1]};
	assign ovf      = (top >= den);
	assign shifted  = {rem_q, num_q[SAMPLE_BITS-1]};
	assign ge       = (shifted >= {1'b0, den});
	assign rem_nxt  = ge ? PROD_BITS'(shifted - {1'b0, den}) : PROD_BITS'(shifted);
	assign peak_max = (item.mag > peak_q) ? item.mag : peak_q;
	assign out_free = !out_vld_q || results.ready;

	always_comb begin
		state_d      = state_q;
		pop          = 1'b0;
		out_load     = 1'b0;
		out_sample_d = item.bits;
		out_peak_d   = peak_q;
		peak_load    = 1'b0;
		div_start    = 1'b0;
		div_step     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (item_valid && out_free) begin
					pop = 1'b1;
					unique case (item.op)
						OP_MEASURE: begin
							peak_load  = 1'b1;
							out_load   = 1'b1;
							out_peak_d = peak_max;
						end
						OP_SCALE: begin
							priority if (peak_q == '0) begin
								out_load = 1'b1;
							end else if (ovf) begin
								out_load     = 1'b1;
								out_sample_d = sat_result(item.neg, 1'b1, '0);
							end else begin
								div_start = 1'b1;
								state_d   = ST_DIV;
							end
						end
						default: begin
							out_load = 1'b0;
						end
					endcase
				end
			end
			ST_DIV: begin
				div_step = 1'b1;
				if (cnt_q == STEP_BITS'(1)) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (out_free) begin
					out_load     = 1'b1;
					out_sample_d = sat_result(neg_q, 1'b0, quo_q);
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			peak_q    <= '0;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (peak_load) begin
				peak_q <= peak_max;
			end
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (results.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (div_start) begin
			rem_q <= top;
			num_q <= {prod[0], {FRAC_BITS{1'b0}}};
			quo_q <= '0;
			cnt_q <= STEP_BITS'(SAMPLE_BITS);
			neg_q <= item.neg;
		end else if (div_step) begin
			rem_q <= rem_nxt;
			num_q <= {num_q[SAMPLE_BITS-2:0], 1'b0};
			quo_q <= {quo_q[SAMPLE_BITS-2:0], ge};
			cnt_q <= cnt_q - STEP_BITS'(1);
		end
		if (out_load) begin
			out_sample_q <= out_sample_d;
			out_peak_q   <= out_peak_d;
		end
	end

	assign results.valid      = out_vld_q;
	assign results.sample_out = out_sample_q;
	assign results.peak_level = out_peak_q;

endmodule

[rtl/pn_chk.sv]
// Port-level assertions of the peak normalizer and their bind.
module pn_chk (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_ready,
	input logic                           out_valid,
	input logic                           out_ready,
	input logic [pn_pkg::SAMPLE_BITS-1:0] peak_level
);
	import pn_pkg::*;

	logic [SAMPLE_BITS-1:0] last_peak_q;
	logic [2:0]             pending_q;
	logic                   in_beat;
	logic                   out_beat;

	assign in_beat  = in_valid && in_ready;
	assign out_beat = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_peak_q <= '0;
			pending_q   <= '0;
		end else begin
			if (out_beat) begin
				last_peak_q <= peak_level;
			end
			pending_q <= pending_q + 3'(in_beat) - 3'(out_beat);
		end
	end

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result beat dropped while stalled");

	a_peak_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> peak_level <= FULL_MAG)
		else $error("peak above full scale");

	a_peak_monotone: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> peak_level >= last_peak_q)
		else $error("peak decreased between result beats");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pending_q != 3'd0)
		else $error("result beat without an outstanding input beat");

	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= 3'd4)
		else $error("more beats in flight than storage allows");

endmodule

bind peak_normalizer pn_chk u_pn_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (samples.valid),
	.in_ready   (samples.ready),
	.out_valid  (results.valid),
	.out_ready  (results.ready),
	.peak_level (results.peak_level)
);
